@@ rtl/bcdc_pkg.sv @@
// shared types, constants and character mapping functions for the base64 stream codec
`default_nettype none

package bcdc_pkg;

   localparam int QueueDepthDefault = 2;

   localparam logic ModeEncode = 1'b0;
   localparam logic ModeDecode = 1'b1;

   localparam logic [7:0] PadChar = 8'h3D;

   // one group's worth of work for the back end
   typedef struct packed {
      logic [3:0][7:0] chars;    // result bytes, index 0 goes out first
      logic [1:0]      cnt_m1;   // number of results minus one
      logic            last;     // final group of the stream
      logic            no_data;  // terminator only
   } cmd_type;

   // six-bit value to alphabet character
   function automatic logic [7:0] enc_char(input logic [5:0] sym);
      logic [7:0] res;
      res = {2'b00, sym};
      if (sym < 6'd26) begin
         res = 8'h41 + {2'b00, sym};
      end else if (sym < 6'd52) begin
         res = 8'h61 + {2'b00, sym} - 8'd26;
      end else if (sym < 6'd62) begin
         res = 8'h30 + {2'b00, sym} - 8'd52;
      end else if (sym == 6'd62) begin
         res = 8'h2B;
      end else begin
         res = 8'h2F;
      end
      return res;
   endfunction

   // alphabet character to six-bit value, anything else maps to 63
   function automatic logic [5:0] dec_value(input logic [7:0] c);
      logic [7:0] res;
      res = 8'd63;
      if (c >= 8'h41 && c <= 8'h5A) begin
         res = c - 8'h41;
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         res = c - 8'h61 + 8'd26;
      end else if (c >= 8'h30 && c <= 8'h39) begin
         res = c - 8'h30 + 8'd52;
      end else if (c == 8'h2B) begin
         res = 8'd62;
      end
      return res[5:0];
   endfunction

endpackage

`default_nettype wire

@@ rtl/base64_stream_codec.sv @@
// top level of the streaming base64 encoder and decoder
`default_nettype none

// Streaming base64 codec with the standard alphabet and '=' padding.
// csr_wr_data selects the mode (0 encode bytes to text, 1 decode text to
// bytes); a write also drops any partly gathered group, so write it only
// between streams while nothing is in flight. The front end takes one
// beat per cycle while the queue has room, gathers groups of three bytes
// or four characters, and turns each completed or final group into one
// command with up to four result bytes. A short queue holds the commands
// and the back end sends one result beat per cycle, unless stalled,
// through a registered output. Throughput: decoding keeps pace at one
// input beat per cycle unless stalled; encoding is bound by the single
// output port, four result beats for every three input bytes. A result
// is held in the queue and then in the output register. On decode, a
// final group shorter than four characters yields one beat with
// rsp_no_data and rsp_out_last set and rsp_out_byte zero.

module base64_stream_codec #(
   parameter int QueueDepth = bcdc_pkg::QueueDepthDefault
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // mode register
   input  wire logic       csr_wr_en,
   input  wire logic       csr_wr_data,
   // input beats
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_last_in,
   // result beats
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      logic [7:0] rsp_out_byte,
   output      logic       rsp_out_last,
   output      logic       rsp_no_data
);

   // front to queue
   logic              push;
   bcdc_pkg::cmd_type push_cmd;
   logic              q_full;

   // queue to back
   bcdc_pkg::cmd_type head_cmd;
   logic              q_empty;
   logic              pop;

   // group gathering and command building
   bcdc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .req_last_in (req_last_in),
      .push        (push),
      .push_cmd    (push_cmd),
      .q_full      (q_full)
   );

   // decouples input stalls from output stalls
   bcdc_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (pop),
      .head_cmd (head_cmd),
      .empty    (q_empty)
   );

   // one result beat per cycle unless the output is stalled
   bcdc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_cmd     (head_cmd),
      .q_empty      (q_empty),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last),
      .rsp_no_data  (rsp_no_data)
   );

endmodule

`default_nettype wire

@@ rtl/bcdc_queue.sv @@
// small command queue between the front and back ends
`default_nettype none

module bcdc_queue #(
   parameter int Depth = bcdc_pkg::QueueDepthDefault
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire bcdc_pkg::cmd_type push_cmd,
   output      logic              full,
   input  wire logic              pop,
   output      bcdc_pkg::cmd_type head_cmd,
   output      logic              empty
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   bcdc_pkg::cmd_type mem [Depth];

   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   logic do_push, do_pop;

   assign full     = (count_ff == CntW'(Depth));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign head_cmd = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

@@ rtl/bcdc_front.sv @@
// front end: mode register, group gathering and per-group command building
`default_nettype none

module bcdc_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_wr_en,
   input  wire logic              csr_wr_data,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire logic [7:0]        req_in_byte,
   input  wire logic              req_last_in,
   output      logic              push,
   output      bcdc_pkg::cmd_type push_cmd,
   input  wire logic              q_full
);

   logic        mode_ff, mode_in;
   logic [17:0] bits_ff, bits_in;
   logic [1:0]  pos_ff, pos_in;
   logic        pad_ff, pad_in;

   logic       accept;
   logic [5:0] val;
   logic       is_pad;
   logic [7:0] b0, b1;
   logic [5:0] s0, s1, s2;

   assign req_stall = q_full;
   assign accept    = req_valid & ~q_full;
   assign val       = bcdc_pkg::dec_value(req_in_byte);
   assign is_pad    = (req_in_byte == bcdc_pkg::PadChar);
   assign s0        = bits_ff[17:12];
   assign s1        = bits_ff[11:6];
   assign s2        = bits_ff[5:0];

   always_comb begin
      mode_in  = mode_ff;
      bits_in  = bits_ff;
      pos_in   = pos_ff;
      pad_in   = pad_ff;
      push     = 1'b0;
      push_cmd = '0;
      b0       = bits_ff[15:8];
      b1       = bits_ff[7:0];
      if (csr_wr_en) begin
         mode_in = csr_wr_data;
         bits_in = '0;
         pos_in  = '0;
         pad_in  = 1'b0;
      end else if (accept) begin
         if (mode_ff == bcdc_pkg::ModeEncode) begin
            if (pos_ff[1]) begin
               // full group of three
               push              = 1'b1;
               push_cmd.chars[0] = bcdc_pkg::enc_char(b0[7:2]);
               push_cmd.chars[1] = bcdc_pkg::enc_char({b0[1:0], b1[7:4]});
               push_cmd.chars[2] = bcdc_pkg::enc_char({b1[3:0], req_in_byte[7:6]});
               push_cmd.chars[3] = bcdc_pkg::enc_char(req_in_byte[5:0]);
               push_cmd.cnt_m1   = 2'd3;
               push_cmd.last     = req_last_in;
               bits_in           = '0;
               pos_in            = '0;
               pad_in            = 1'b0;
            end else if (!req_last_in) begin
               bits_in = {2'b00, bits_ff[7:0], req_in_byte};
               pos_in  = pos_ff + 1'b1;
            end else begin
               push            = 1'b1;
               push_cmd.cnt_m1 = 2'd3;
               push_cmd.last   = 1'b1;
               if (pos_ff == 2'd0) begin
                  // lone byte, two pad characters
                  push_cmd.chars[0] = bcdc_pkg::enc_char(req_in_byte[7:2]);
                  push_cmd.chars[1] = bcdc_pkg::enc_char({req_in_byte[1:0], 4'b0000});
                  push_cmd.chars[2] = bcdc_pkg::PadChar;
               end else begin
                  push_cmd.chars[0] = bcdc_pkg::enc_char(b1[7:2]);
                  push_cmd.chars[1] = bcdc_pkg::enc_char({b1[1:0], req_in_byte[7:4]});
                  push_cmd.chars[2] = bcdc_pkg::enc_char({req_in_byte[3:0], 2'b00});
               end
               push_cmd.chars[3] = bcdc_pkg::PadChar;
               bits_in           = '0;
               pos_in            = '0;
               pad_in            = 1'b0;
            end
         end else begin
            if (pos_ff != 2'd3) begin
               if (req_last_in) begin
                  // short final group is dropped
                  push             = 1'b1;
                  push_cmd.cnt_m1  = 2'd0;
                  push_cmd.last    = 1'b1;
                  push_cmd.no_data = 1'b1;
                  bits_in          = '0;
                  pos_in           = '0;
                  pad_in           = 1'b0;
               end else begin
                  bits_in = {bits_ff[11:0], val};
                  if (pos_ff == 2'd2) begin
                     pad_in = is_pad;
                  end
                  pos_in = pos_ff + 1'b1;
               end
            end else begin
               push              = 1'b1;
               push_cmd.chars[0] = {s0, s1[5:4]};
               push_cmd.chars[1] = {s1[3:0], s2[5:2]};
               push_cmd.chars[2] = {s2[1:0], val};
               push_cmd.cnt_m1   = 2'd2;
               if (req_last_in && is_pad) begin
                  push_cmd.cnt_m1 = pad_ff ? 2'd0 : 2'd1;
               end
               push_cmd.last = req_last_in;
               bits_in       = '0;
               pos_in        = '0;
               pad_in        = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= bcdc_pkg::ModeEncode;
         bits_ff <= '0;
         pos_ff  <= '0;
         pad_ff  <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         bits_ff <= bits_in;
         pos_ff  <= pos_in;
         pad_ff  <= pad_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/bcdc_back.sv @@
// back end: walks the head command into the output register one result per cycle unless stalled
`default_nettype none

module bcdc_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire bcdc_pkg::cmd_type head_cmd,
   input  wire logic              q_empty,
   output      logic              pop,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      logic [7:0]        rsp_out_byte,
   output      logic              rsp_out_last,
   output      logic              rsp_no_data
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       last_ff, nodata_ff;

   logic load;
   logic at_end;

   assign load   = ~q_empty & (~valid_ff | ~rsp_stall);
   assign at_end = (idx_ff == head_cmd.cnt_m1);
   assign pop    = load & at_end;

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_out_last = last_ff;
   assign rsp_no_data  = nodata_ff;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = at_end ? 2'd0 : idx_ff + 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff   <= head_cmd.chars[idx_ff];
         last_ff   <= head_cmd.last & at_end;
         nodata_ff <= head_cmd.no_data;
      end
   end

endmodule

`default_nettype wire
